// ----- rtl/affg_pkg.sv -----
// Shared types and codes for the affine-gap global aligner.
// No dependencies.
package affg_pkg;

	localparam logic [1:0] DIR_MATCH    = 2'd0;
	localparam logic [1:0] DIR_MISMATCH = 2'd1;
	localparam logic [1:0] DIR_DEL      = 2'd2;
	localparam logic [1:0] DIR_INS      = 2'd3;

	localparam logic [1:0] REL_MATCH    = 2'd0;
	localparam logic [1:0] REL_MISMATCH = 2'd1;
	localparam logic [1:0] REL_GAP      = 2'd2;

	localparam logic [7:0] GAP_CHAR = 8'd95;

	localparam logic [1:0] REG_MATCH    = 2'd0;
	localparam logic [1:0] REG_MISMATCH = 2'd1;
	localparam logic [1:0] REG_OPEN     = 2'd2;
	localparam logic [1:0] REG_EXTEND   = 2'd3;

	typedef struct packed {
		logic       mode;
		logic [7:0] symbol;
		logic       last;
	} in_t;

	typedef struct packed {
		logic [7:0]         ref_symbol;
		logic [7:0]         query_symbol;
		logic [1:0]         relation;
		logic signed [15:0] score;
		logic               overflow;
		logic               last_res;
	} out_t;

	typedef struct packed {
		logic signed [7:0] match_s;
		logic signed [7:0] mismatch_s;
		logic signed [7:0] open_s;
		logic signed [7:0] extend_s;
	} score_cfg_t;

	typedef struct packed {
		logic signed [15:0] above;
		logic signed [15:0] del;
		logic signed [15:0] left;
		logic signed [15:0] ins;
		logic signed [15:0] diag;
		logic               sym_eq;
		logic               first_row;
		logic               first_col;
	} cell_in_t;

	typedef struct packed {
		logic signed [15:0] dv;
		logic signed [15:0] iv;
		logic signed [15:0] best;
		logic [1:0]         dir;
		logic               dop;
		logic               iop;
	} cell_out_t;

endpackage

// ----- rtl/affg_cell_unit.sv -----
// Shared cell arithmetic: one score cell of the three matrices per use.
// Depends on affg_pkg.
module affg_cell_unit import affg_pkg::*; (
	input  score_cfg_t cfg,
	input  cell_in_t   ci,
	output cell_out_t  co
);

	logic signed [15:0] ext, oe, d_ext, i_ext, dv, iv, diag_sc, best;
	logic               dop, iop;
	logic [1:0]         dir;

	always_comb begin
		ext     = 16'(cfg.extend_s);
		oe      = 16'(cfg.open_s) + ext;
		d_ext   = ci.del + ext;
		i_ext   = ci.ins + ext;
		dv      = ci.above + oe;
		dop     = 1'b1;
		if (!ci.first_row && d_ext > dv) begin
			dv  = d_ext;
			dop = 1'b0;
		end
		iv      = ci.left + oe;
		iop     = 1'b1;
		if (!ci.first_col && i_ext > iv) begin
			iv  = i_ext;
			iop = 1'b0;
		end
		if (ci.sym_eq) begin
			diag_sc = ci.diag + 16'(cfg.match_s);
			dir     = DIR_MATCH;
		end else begin
			diag_sc = ci.diag + 16'(cfg.mismatch_s);
			dir     = DIR_MISMATCH;
		end
		best = diag_sc;
		if (dv >= best) begin
			best = dv;
			dir  = DIR_DEL;
		end
		if (iv >= best) begin
			best = iv;
			dir  = DIR_INS;
		end
		co.dv   = dv;
		co.iv   = iv;
		co.best = best;
		co.dir  = dir;
		co.dop  = dop;
		co.iop  = iop;
	end

endmodule

// ----- rtl/affine_gap_global_aligner.sv -----
// Top level of the affine-gap global aligner: loader, fill and traceback
// sequencer, symbol, row and pointer memories. Depends on affg_pkg and
// affg_cell_unit.
//
// Each accepted request loads one reference (mode 0) or query (mode 1)
// symbol. A query request with last set starts the job: S_INIT fills the top
// row, then each query row is set up in S_ROW and each of its cells goes
// through the single cell unit in S_CA (read the row memories) and S_CB
// (compute and write back). Each traceback step reads pointer and symbols in
// S_TR and decides in S_TE, which waits while the output register still holds
// a column; a step yields one result except where the main matrix hands over
// to a gap matrix, which costs one extra step. in_ready is low from job start
// until the final column has been placed in the output register.
// Symbols beyond the store depth are dropped and flagged on every column of
// that job. Lengths and the flag clear when the final column is issued.
module affine_gap_global_aligner import affg_pkg::*; #(
	parameter int MAX_REF_LEN   = 32,
	parameter int MAX_QUERY_LEN = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_t        in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_t       out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	// length counters hold 0..MAX; addresses index 0..MAX-1
	localparam int RLW = $clog2(MAX_REF_LEN + 1);
	localparam int QLW = $clog2(MAX_QUERY_LEN + 1);
	localparam int RAW = (MAX_REF_LEN > 1) ? $clog2(MAX_REF_LEN) : 1;
	localparam int QAW = (MAX_QUERY_LEN > 1) ? $clog2(MAX_QUERY_LEN) : 1;
	localparam int PAW = RLW + QLW;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_INIT = 3'd1; // top row of scores
	localparam logic [2:0] S_ROW  = 3'd2; // row set-up, query symbol read
	localparam logic [2:0] S_CA   = 3'd3; // cell: row memory read
	localparam logic [2:0] S_CB   = 3'd4; // cell: compute, write back
	localparam logic [2:0] S_TR   = 3'd5; // traceback read
	localparam logic [2:0] S_TE   = 3'd6; // traceback decide and emit

	localparam logic [1:0] TB_MAIN = 2'd0;
	localparam logic [1:0] TB_INS  = 2'd1;
	localparam logic [1:0] TB_DEL  = 2'd2;

	logic [2:0]         state_q;
	logic [1:0]         tb_q;
	score_cfg_t         cfg_q;
	logic [RLW-1:0]     rlen_q, j_q;
	logic [QLW-1:0]     qlen_q, i_q;
	logic               ovf_q;
	logic signed [15:0] acc_q, col0_q, diag_q, left_q, ins_q, score_q;
	logic               out_valid_q;
	out_t               out_q;

	// memories
	logic [7:0]         ref_mem [MAX_REF_LEN];
	logic [7:0]         qry_mem [MAX_QUERY_LEN];
	logic signed [15:0] srow_mem [MAX_REF_LEN];
	logic signed [15:0] drow_mem [MAX_REF_LEN];
	logic [3:0]         ptr_mem [2**PAW];
	logic [7:0]         ref_rd, qry_rd;
	logic signed [15:0] srow_rd, drow_rd;
	logic [3:0]         ptr_rd;

	logic [RAW-1:0]     ra;
	logic [QAW-1:0]     qa;
	logic [PAW-1:0]     pa;
	logic               in_acc, ref_we, qry_we, row_we, ptr_we;
	logic [RAW-1:0]     ref_wa;
	logic [QAW-1:0]     qry_wa;
	logic signed [15:0] row_wd, ext, oe, col0_nx;

	cell_in_t  ci;
	cell_out_t co;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign ra     = RAW'(j_q - RLW'(1));
	assign qa     = QAW'(i_q - QLW'(1));
	assign pa     = {i_q, j_q};
	assign ref_wa = RAW'(rlen_q);
	assign qry_wa = QAW'(qlen_q);
	assign ref_we = in_acc && !in_data.mode && (rlen_q < RLW'(MAX_REF_LEN));
	assign qry_we = in_acc && in_data.mode && (qlen_q < QLW'(MAX_QUERY_LEN));
	assign row_we = (state_q == S_INIT && j_q <= rlen_q) || (state_q == S_CB);
	assign row_wd = (state_q == S_CB) ? co.best : acc_q;
	assign ptr_we = (state_q == S_CB);

	assign ext     = 16'(cfg_q.extend_s);
	assign oe      = 16'(cfg_q.open_s) + ext;
	assign col0_nx = (i_q == QLW'(1)) ? oe : col0_q + ext;

	always_ff @(posedge clk) begin
		if (ref_we) ref_mem[ref_wa] <= in_data.symbol;
		if (qry_we) qry_mem[qry_wa] <= in_data.symbol;
		if (row_we) begin
			srow_mem[ra] <= row_wd;
			drow_mem[ra] <= (state_q == S_CB) ? co.dv : acc_q;
		end
		if (ptr_we) ptr_mem[pa] <= {co.dir, co.iop, co.dop};
		if (state_q == S_CA || state_q == S_TR) ref_rd <= ref_mem[ra];
		if (state_q == S_ROW || state_q == S_TR) qry_rd <= qry_mem[qa];
		if (state_q == S_CA) begin
			srow_rd <= srow_mem[ra];
			drow_rd <= drow_mem[ra];
		end
		if (state_q == S_TR) ptr_rd <= ptr_mem[pa];
	end

	assign ci.above     = srow_rd;
	assign ci.del       = drow_rd;
	assign ci.left      = left_q;
	assign ci.ins       = ins_q;
	assign ci.diag      = diag_q;
	assign ci.sym_eq    = (ref_rd == qry_rd);
	assign ci.first_row = (i_q == QLW'(1));
	assign ci.first_col = (j_q == RLW'(1));

	affg_cell_unit u_cell (
		.cfg (cfg_q),
		.ci  (ci),
		.co  (co)
	);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.match_s    <= 8'sd1;
			cfg_q.mismatch_s <= -8'sd1;
			cfg_q.open_s     <= -8'sd2;
			cfg_q.extend_s   <= -8'sd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MATCH:    cfg_q.match_s    <= cfg_data;
				REG_MISMATCH: cfg_q.mismatch_s <= cfg_data;
				REG_OPEN:     cfg_q.open_s     <= cfg_data;
				REG_EXTEND:   cfg_q.extend_s   <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rlen_q      <= '0;
			qlen_q      <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			tb_q        <= TB_MAIN;
			i_q         <= '0;
			j_q         <= '0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (!in_data.mode) begin
							if (ref_we) rlen_q <= rlen_q + RLW'(1);
							else        ovf_q  <= 1'b1;
						end else begin
							if (qry_we) qlen_q <= qlen_q + QLW'(1);
							else        ovf_q  <= 1'b1;
							if (in_data.last) begin
								state_q <= S_INIT;
								j_q     <= RLW'(1);
								acc_q   <= oe;
								col0_q  <= '0;
							end
						end
					end
				end
				S_INIT: begin
					if (j_q >= rlen_q) begin
						state_q <= S_ROW;
						i_q     <= QLW'(1);
					end else begin
						j_q   <= j_q + RLW'(1);
						acc_q <= acc_q + ext;
					end
				end
				S_ROW: begin
					col0_q <= col0_nx;
					if (rlen_q == '0) begin
						// empty reference: only the left edge moves
						if (i_q == qlen_q) begin
							score_q <= col0_nx;
							j_q     <= '0;
							tb_q    <= TB_MAIN;
							state_q <= S_TR;
						end else begin
							i_q <= i_q + QLW'(1);
						end
					end else begin
						diag_q  <= col0_q;
						left_q  <= col0_nx;
						j_q     <= RLW'(1);
						state_q <= S_CA;
					end
				end
				S_CA: state_q <= S_CB;
				S_CB: begin
					diag_q <= srow_rd;
					left_q <= co.best;
					ins_q  <= co.iv;
					if (j_q == rlen_q) begin
						if (i_q == qlen_q) begin
							score_q <= co.best;
							tb_q    <= TB_MAIN;
							state_q <= S_TR;
						end else begin
							i_q     <= i_q + QLW'(1);
							state_q <= S_ROW;
						end
					end else begin
						j_q     <= j_q + RLW'(1);
						state_q <= S_CA;
					end
				end
				S_TR: state_q <= S_TE;
				S_TE: begin
					if (!out_valid_q) begin
						logic emit, last_col;
						logic [QLW-1:0] i_nx;
						logic [RLW-1:0] j_nx;
						emit = 1'b1;
						i_nx = i_q;
						j_nx = j_q;
						out_q.score    <= score_q;
						out_q.overflow <= ovf_q;
						out_q.relation <= REL_GAP;
						out_q.ref_symbol   <= GAP_CHAR;
						out_q.query_symbol <= GAP_CHAR;
						if (i_q != '0 && j_q != '0) begin
							unique case (tb_q)
								TB_MAIN: begin
									if (ptr_rd[3:2] == DIR_MATCH ||
										ptr_rd[3:2] == DIR_MISMATCH) begin
										out_q.ref_symbol   <= ref_rd;
										out_q.query_symbol <= qry_rd;
										out_q.relation <= (ptr_rd[3:2] == DIR_MATCH) ?
											REL_MATCH : REL_MISMATCH;
										i_nx = i_q - QLW'(1);
										j_nx = j_q - RLW'(1);
									end else begin
										emit = 1'b0;
										tb_q <= (ptr_rd[3:2] == DIR_INS) ? TB_INS : TB_DEL;
									end
								end
								TB_INS: begin
									out_q.ref_symbol <= ref_rd;
									tb_q <= ptr_rd[1] ? TB_MAIN : TB_INS;
									j_nx = j_q - RLW'(1);
								end
								default: begin
									out_q.query_symbol <= qry_rd;
									tb_q <= ptr_rd[0] ? TB_MAIN : TB_DEL;
									i_nx = i_q - QLW'(1);
								end
							endcase
						end else if (i_q != '0) begin
							out_q.query_symbol <= qry_rd;
							i_nx = i_q - QLW'(1);
						end else begin
							out_q.ref_symbol <= ref_rd;
							j_nx = j_q - RLW'(1);
						end
						last_col = emit && (i_nx == '0) && (j_nx == '0);
						out_q.last_res <= last_col;
						if (emit) out_valid_q <= 1'b1;
						i_q <= i_nx;
						j_q <= j_nx;
						if (last_col) begin
							state_q <= S_IDLE;
							rlen_q  <= '0;
							qlen_q  <= '0;
							ovf_q   <= 1'b0;
						end else begin
							state_q <= S_TR;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_rlen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rlen_q <= RLW'(MAX_REF_LEN)) else $error("reference length beyond store");
	a_qlen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qlen_q <= QLW'(MAX_QUERY_LEN)) else $error("query length beyond store");
	a_cell_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CB) |-> (j_q != '0 && j_q <= rlen_q && i_q != '0 && i_q <= qlen_q))
		else $error("cell index outside matrix");
	a_tb_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TE) |-> (i_q != '0 || j_q != '0)) else $error("traceback past origin");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(out_q)))
		else $error("column changed while stalled");
`endif

endmodule
